// File: src/wprl_pkg.sv
package wprl_pkg;

  // Table geometry
  localparam int RULES_PER_TABLE = 8;
  localparam int NUM_TABLES      = 4;
  localparam int NUM_SLOTS       = NUM_TABLES * RULES_PER_TABLE;
  localparam int SLOT_W          = $clog2(NUM_SLOTS);
  localparam int SCAN_W          = (RULES_PER_TABLE > 1) ? $clog2(RULES_PER_TABLE) : 1;

  // Stream widths
  localparam int S_TDATA_W = 88;
  localparam int S_TUSER_W = 4;
  localparam int M_TDATA_W = 8;

  // Identifier values
  localparam logic [31:0] ACL_CLUSTER  = 32'h0000_001f;
  localparam logic [31:0] BAD_CLUSTER  = 32'hffff_ffff;
  localparam logic [15:0] BAD_ENDPOINT = 16'hffff;
  localparam logic [31:0] BAD_FIELD    = 32'hffff_ffff;

  // Privilege codes
  localparam logic [2:0] PRIV_VIEW    = 3'd0;
  localparam logic [2:0] PRIV_OPERATE = 3'd2;
  localparam logic [2:0] PRIV_ADMIN   = 3'd4;

  // Table codes
  localparam logic [1:0] TBL_WRITE_ATTR = 2'd1;
  localparam logic [1:0] TBL_INVOKE     = 2'd2;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_WRITE  = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_QUERY = 2'd1,
    ST_REJECT    = 2'd2
  } status_t;

  // Work handed from front end to back end
  typedef enum logic [1:0] {
    CMD_LOOKUP,
    CMD_WRITE,
    CMD_CLEAR,
    CMD_REPLY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       cluster;
    logic [15:0]       endpoint;
    logic [31:0]       field;
    logic [2:0]        priv;
    status_t           status;
  } cmd_t;

  typedef struct packed {
    logic [31:0] cluster;
    logic [15:0] endpoint;
    logic [31:0] field;
    logic [2:0]  priv;
  } rule_t;

  localparam rule_t RULE_EMPTY = '{BAD_CLUSTER, BAD_ENDPOINT, BAD_FIELD, PRIV_VIEW};
  localparam rule_t RULE_LEAD  = '{ACL_CLUSTER, BAD_ENDPOINT, BAD_FIELD, PRIV_ADMIN};

  function automatic logic [2:0] default_priv(input logic [1:0] tbl);
    return (tbl == TBL_WRITE_ATTR || tbl == TBL_INVOKE) ? PRIV_OPERATE : PRIV_VIEW;
  endfunction

endpackage

// File: src/wprl_front.sv
module wprl_front import wprl_pkg::*; (
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // cluster_id[31:0], endpoint_id[47:32], field_id[79:48],
  // privilege_level[82:80], entry_index[85:83], zero[87:86]
  input  logic [S_TDATA_W-1:0] s_tdata,
  // opcode[1:0], table_select[3:2]
  input  logic [S_TUSER_W-1:0] s_tuser,
  input  logic                 q_full,
  output logic                 push,
  output cmd_t                 cmd
);

  logic [1:0]        opcode;
  logic [1:0]        tbl;
  logic [31:0]       cluster;
  logic [15:0]       endpoint;
  logic [31:0]       field;
  logic [2:0]        pv;
  logic [2:0]        idx;
  logic [SLOT_W-1:0] base;
  logic              bad_query;
  logic              bad_target;
  logic              weak_priv;

  // Unpack the beat
  assign opcode   = s_tuser[1:0];
  assign tbl      = s_tuser[3:2];
  assign cluster  = s_tdata[31:0];
  assign endpoint = s_tdata[47:32];
  assign field    = s_tdata[79:48];
  assign pv       = s_tdata[82:80];
  assign idx      = s_tdata[85:83];

  assign base = SLOT_W'(int'(tbl) * RULES_PER_TABLE);

  // Argument checks
  assign bad_query  = (cluster == BAD_CLUSTER) || (endpoint == BAD_ENDPOINT) ||
                      (field == BAD_FIELD);
  assign bad_target = (cluster == ACL_CLUSTER) || (cluster == BAD_CLUSTER) ||
                      (int'(idx) >= RULES_PER_TABLE);
  assign weak_priv  = (pv == PRIV_VIEW) || (pv > PRIV_ADMIN) ||
                      (pv == PRIV_OPERATE && (tbl == TBL_WRITE_ATTR || tbl == TBL_INVOKE));

  assign s_tready = ~q_full;
  assign push     = s_tvalid & s_tready;

  // Classify the beat into a back-end command
  always_comb begin
    cmd.kind     = CMD_REPLY;
    cmd.slot     = base;
    cmd.cluster  = cluster;
    cmd.endpoint = endpoint;
    cmd.field    = field;
    cmd.priv     = PRIV_VIEW;
    cmd.status   = ST_REJECT;
    unique case (opcode)
      OP_LOOKUP: begin
        cmd.priv = default_priv(tbl);
        if (bad_query) begin
          cmd.status = ST_BAD_QUERY;
        end else begin
          cmd.kind   = CMD_LOOKUP;
          cmd.status = ST_OK;
        end
      end
      OP_WRITE: begin
        if (!bad_target && !weak_priv) begin
          cmd.kind   = CMD_WRITE;
          cmd.slot   = base + SLOT_W'(idx);
          cmd.priv   = pv;
          cmd.status = ST_OK;
        end
      end
      OP_CLEAR: begin
        if (!bad_target) begin
          cmd.kind   = CMD_CLEAR;
          cmd.slot   = base + SLOT_W'(idx);
          cmd.status = ST_OK;
        end
      end
      default: begin
        cmd.status = ST_REJECT;
      end
    endcase
  end

endmodule

// File: src/wprl_queue.sv
module wprl_queue import wprl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic avail,
  output cmd_t head
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign head  = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop && avail) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop && avail);
    end
  end

  // Store command payload
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

endmodule

// File: src/wprl_back.sv
module wprl_back import wprl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_avail,
  input  cmd_t                 q_head,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // required_privilege[2:0], rule_matched[3], status[5:4], zero[7:6]
  output logic [M_TDATA_W-1:0] m_tdata
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RESP} state_t;

  state_t            state;
  cmd_t              cmd;
  logic [SCAN_W-1:0] scan;
  logic [2:0]        res_priv;
  logic              res_matched;
  status_t           res_status;

  rule_t             mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] written;
  rule_t             rd_data;
  logic              rd_written;
  logic              rd_lead;
  logic [SLOT_W-1:0] rd_slot;

  logic              wr_en;
  rule_t             wr_rule;
  rule_t             entry;
  logic              last;
  logic              stop;
  logic              hit;

  assign pop = (state == S_IDLE) && q_avail;

  // Table update from the command at the queue head
  assign wr_en   = pop && (q_head.kind == CMD_WRITE || q_head.kind == CMD_CLEAR);
  assign wr_rule = (q_head.kind == CMD_WRITE) ?
                   rule_t'{q_head.cluster, q_head.endpoint, q_head.field, q_head.priv} :
                   RULE_EMPTY;

  // Scan address: table base on start, next slot while scanning
  assign last = (scan == SCAN_W'(RULES_PER_TABLE - 1));
  always_comb begin
    if (state == S_IDLE) begin
      rd_slot = q_head.slot;
    end else if (last) begin
      rd_slot = cmd.slot;
    end else begin
      rd_slot = cmd.slot + SLOT_W'(scan) + SLOT_W'(1);
    end
  end

  // Slot never written reads as its reset value
  assign entry = rd_written ? rd_data : (rd_lead ? RULE_LEAD : RULE_EMPTY);
  assign stop  = (entry.cluster == BAD_CLUSTER) || (entry.cluster > cmd.cluster);
  assign hit   = (entry.cluster == cmd.cluster) &&
                 (entry.endpoint == cmd.endpoint || entry.endpoint == BAD_ENDPOINT) &&
                 (entry.field == cmd.field || entry.field == BAD_FIELD);

  // Rule memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[q_head.slot] <= wr_rule;
    rd_data <= mem[rd_slot];
  end

  // Written marks and read side flags
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
      rd_lead    <= 1'b0;
    end else begin
      if (wr_en) written[q_head.slot] <= 1'b1;
      rd_written <= written[rd_slot];
      rd_lead    <= (state == S_IDLE);
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_RESP) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_avail) begin
            cmd         <= q_head;
            scan        <= '0;
            res_priv    <= q_head.priv;
            res_matched <= 1'b0;
            res_status  <= q_head.status;
            if (q_head.kind == CMD_LOOKUP) begin
              state <= S_SCAN;
            end else begin
              if (q_head.kind != CMD_REPLY) res_priv <= PRIV_VIEW;
              state <= S_RESP;
            end
          end
        end
        S_SCAN: begin
          if (stop) begin
            state <= S_RESP;
          end else if (hit) begin
            res_priv    <= entry.priv;
            res_matched <= 1'b1;
            state       <= S_RESP;
          end else if (last) begin
            state <= S_RESP;
          end else begin
            scan <= scan + SCAN_W'(1);
          end
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, res_status, res_matched, res_priv};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/wildcard_privilege_rule_lookup_core.sv
// Flow: a lookup examines 1 to RULES_PER_TABLE rules via the registered rule memory read,
// then its result is registered on m_tdata; write, clear and rejected beats go straight
// to the result register. Throughput: the back-end sequencer reads one rule per cycle
// from the rule memory and pops the next beat only after registering a result; a
// two-entry queue buffers new beats. Reset: synchronous, clears control and marks every
// slot unwritten, so all tables read their reset rules at once with no clearing pass.
module wildcard_privilege_rule_lookup_core import wprl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // cluster_id[31:0], endpoint_id[47:32], field_id[79:48],
  // privilege_level[82:80], entry_index[85:83], zero[87:86]
  input  logic [S_TDATA_W-1:0] s_tdata,
  // opcode[1:0], table_select[3:2]
  input  logic [S_TUSER_W-1:0] s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // required_privilege[2:0], rule_matched[3], status[5:4], zero[7:6]
  output logic [M_TDATA_W-1:0] m_tdata
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_avail;
  logic pop;
  cmd_t q_head;

  wprl_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  wprl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .avail    (q_avail),
    .head     (q_head)
  );

  wprl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_avail  (q_avail),
    .q_head   (q_head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // A matched rule always carries a real privilege and an ok status
  a_match_priv: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> (m_tdata[2:0] != PRIV_VIEW) && (m_tdata[5:4] == ST_OK))
    else $error("matched result with view privilege or bad status");

  // Rejected beats report no privilege and no match
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[5:4] == ST_REJECT) |-> (m_tdata[3:0] == 4'd0))
    else $error("rejected result carries privilege or match");

  // Invalid queries never report a match
  a_bad_query: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[5:4] == ST_BAD_QUERY) |-> !m_tdata[3])
    else $error("invalid query reported a match");

  // No result appears right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule
